// ===== sv/process_table_scheduler_macros.svh =====
// Assertion macros for the process table scheduler.
`ifndef PROCESS_TABLE_SCHEDULER_MACROS_SVH
`define PROCESS_TABLE_SCHEDULER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define PTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/pts_pkg.sv =====
// Shared types and constants of the process table scheduler.
package pts_pkg;

  localparam int NUM_ENTRIES = 64;
  localparam int IDX_W       = $clog2(NUM_ENTRIES);
  localparam int LEVEL_DIV   = 10;
  localparam int LEVEL_RECIP = (1 << 16) / LEVEL_DIV + 1;

  localparam logic [2:0] CMD_WRITE  = 3'd0;
  localparam logic [2:0] CMD_READY  = 3'd1;
  localparam logic [2:0] CMD_RESUME = 3'd2;
  localparam logic [2:0] CMD_STOP   = 3'd3;
  localparam logic [2:0] CMD_SCHED  = 3'd4;

  localparam logic [2:0] ST_READY   = 3'd1;
  localparam logic [2:0] ST_RUNNING = 3'd2;
  localparam logic [2:0] ST_STOPPED = 3'd3;

  localparam logic [1:0] REG_POLICY  = 2'd0;
  localparam logic [1:0] REG_QUANTUM = 2'd1;
  localparam logic [1:0] REG_UPRIO   = 2'd2;

  typedef struct packed {
    logic [2:0]        state;
    logic signed [7:0] prio;
    logic [5:0]        nice;
    logic [15:0]       counter;
  } entry_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic load;
    logic fetch;
    logic prep;
    logic scan;
    logic win;
  } ctl_t;

  // Datapath status to the controller.
  typedef struct packed {
    logic sched;
    logic scan_last;
  } sts_t;

endpackage

// ===== sv/process_table_scheduler.sv =====
// Top level of the process table scheduler: controller, datapath and checks.
//
//   channel   handshake            payload
//   command   start / busy         cmd, slot, new_state, new_priority, new_nice, new_counter
//   result    done (one cycle)     chosen, switched, previous, rd_state, rd_priority,
//                                  rd_nice, rd_counter
//   config    cfg_we               cfg_idx, cfg_data
//
// Write, ready, resume and read commands pass the fetch and prepare states before done.
// A schedule also passes them, then walks the table: the walk reads one table entry a cycle
// through the single read port of the entry table, and a drain state precedes the winner.
// Synchronous reset marks every entry unused at once through per-entry valid bits.
// The receiver cannot stall: done is high for one cycle and busy drops with it.
`include "process_table_scheduler_macros.svh"

module process_table_scheduler (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        cmd,
  input  logic [5:0]        slot,
  input  logic [2:0]        new_state,
  input  logic signed [7:0] new_priority,
  input  logic [5:0]        new_nice,
  input  logic [15:0]       new_counter,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_idx,
  input  logic [9:0]        cfg_data,
  output logic              done,
  output logic [5:0]        chosen,
  output logic              switched,
  output logic [5:0]        previous,
  output logic [2:0]        rd_state,
  output logic signed [7:0] rd_priority,
  output logic [5:0]        rd_nice,
  output logic [15:0]       rd_counter
);

  pts_pkg::ctl_t ctl;
  pts_pkg::sts_t sts;

  // Sequence the phases of each command
  pts_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  // Hold the table, walk it and register the result
  pts_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .sts          (sts),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .slot         (slot),
    .new_state    (new_state),
    .new_priority (new_priority),
    .new_nice     (new_nice),
    .new_counter  (new_counter),
    .done         (done),
    .chosen       (chosen),
    .switched     (switched),
    .previous     (previous),
    .rd_state     (rd_state),
    .rd_priority  (rd_priority),
    .rd_nice      (rd_nice),
    .rd_counter   (rd_counter)
  );

  `PTS_ASSERT_NOW(a_done_idle, done, !busy, "result while still busy")
  `PTS_ASSERT_NEXT(a_start_busy, start && !busy, busy, "transfer did not start work")
  `PTS_ASSERT_NEXT(a_win_done, ctl.win, done && (chosen == previous) == !switched, "winner result wrong")
  `PTS_ASSERT_NOW(a_one_phase, 1'b1, $onehot0(ctl), "controller issued two phases at once")

endmodule

// ===== sv/pts_ctrl.sv =====
// Sequencing state machine of the process table scheduler.
module pts_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  pts_pkg::sts_t sts,
  output pts_pkg::ctl_t ctl,
  output logic          busy
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FETCH = 6'b000010,
    S_PREP  = 6'b000100,
    S_SCAN  = 6'b001000,
    S_DRAIN = 6'b010000,
    S_WIN   = 6'b100000
  } fsm_t;

  fsm_t fsm, fsm_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm <= S_IDLE;
    end else begin
      fsm <= fsm_next;
    end
  end

  always_comb begin
    fsm_next = fsm;
    ctl      = '0;
    unique case (fsm)
      S_IDLE: begin
        if (start) begin
          ctl.load = 1'b1;
          fsm_next = S_FETCH;
        end
      end
      S_FETCH: begin
        ctl.fetch = 1'b1;
        fsm_next  = S_PREP;
      end
      S_PREP: begin
        ctl.prep = 1'b1;
        fsm_next = sts.sched ? S_SCAN : S_IDLE;
      end
      S_SCAN: begin
        ctl.scan = 1'b1;
        if (sts.scan_last) begin
          fsm_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        fsm_next = S_WIN;
      end
      S_WIN: begin
        ctl.win  = 1'b1;
        fsm_next = S_IDLE;
      end
      default: begin
        fsm_next = S_IDLE;
      end
    endcase
  end

  assign busy = (fsm != S_IDLE);

endmodule

// ===== sv/pts_dp.sv =====
// Entry table, selection logic and result registers of the process table scheduler.
module pts_dp (
  input  logic                clk,
  input  logic                rst,
  input  pts_pkg::ctl_t       ctl,
  output pts_pkg::sts_t       sts,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_idx,
  input  logic [9:0]          cfg_data,
  input  logic [2:0]          cmd,
  input  logic [5:0]          slot,
  input  logic [2:0]          new_state,
  input  logic signed [7:0]   new_priority,
  input  logic [5:0]          new_nice,
  input  logic [15:0]         new_counter,
  output logic                done,
  output logic [5:0]          chosen,
  output logic                switched,
  output logic [5:0]          previous,
  output logic [2:0]          rd_state,
  output logic signed [7:0]   rd_priority,
  output logic [5:0]          rd_nice,
  output logic [15:0]         rd_counter
);

  localparam int IW = pts_pkg::IDX_W;

  function automatic logic signed [8:0] level_of(input logic signed [7:0] p);
    logic [7:0]  a;
    logic [24:0] prod;
    logic [8:0]  q;
    a    = p[7] ? 8'(-p) : 8'(p);
    prod = 25'(a) * 25'(pts_pkg::LEVEL_RECIP);
    q    = 9'(prod >> 16);
    return p[7] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic beats(input pts_pkg::entry_t c, input pts_pkg::entry_t n,
                                 input logic [1:0] pol);
    logic signed [17:0] kc, kn;
    logic signed [8:0]  lc, ln;
    logic signed [16:0] mc, mn;
    kc = (18'(c.prio) <<< 3) + (18'(c.prio) <<< 1) - $signed({2'b0, c.counter});
    kn = (18'(n.prio) <<< 3) + (18'(n.prio) <<< 1) - $signed({2'b0, n.counter});
    lc = level_of(c.prio);
    ln = level_of(n.prio);
    mc = $signed({11'b0, c.nice}) - $signed({1'b0, c.counter});
    mn = $signed({11'b0, n.nice}) - $signed({1'b0, n.counter});
    if (pol == 2'd0) begin
      return c.counter > n.counter;
    end else if (pol == 2'd1) begin
      return (kc != kn) ? (kc < kn) : (c.nice <= n.nice);
    end else begin
      return (lc == ln) ? (mc <= mn) : (lc < ln);
    end
  endfunction

  function automatic pts_pkg::entry_t bumped(input pts_pkg::entry_t e);
    pts_pkg::entry_t r;
    r = e;
    if (e.counter != 16'hFFFF) begin
      r.counter = e.counter + 16'd1;
    end
    return r;
  endfunction

  // Configuration
  logic [1:0]        policy;
  logic [9:0]        quantum;
  logic signed [7:0] user_prio;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy    <= 2'd2;
      quantum   <= 10'd50;
      user_prio <= 8'sd40;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        pts_pkg::REG_POLICY:  policy    <= cfg_data[1:0];
        pts_pkg::REG_QUANTUM: quantum   <= cfg_data;
        pts_pkg::REG_UPRIO:   user_prio <= $signed(cfg_data[7:0]);
        default: ;
      endcase
    end
  end

  // Latched command
  logic [2:0]      cmd_r;
  logic [5:0]      slot_r;
  pts_pkg::entry_t new_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r  <= cmd;
      slot_r <= slot;
      new_r  <= '{state: new_state, prio: new_priority, nice: new_nice,
                  counter: new_counter};
    end
  end

  logic          is_sched, slot_ok;
  logic [IW-1:0] slot_idx;

  assign is_sched = (cmd_r == pts_pkg::CMD_STOP) || (cmd_r == pts_pkg::CMD_SCHED);
  assign slot_ok  = (32'(slot_r) < 32'(pts_pkg::NUM_ENTRIES));
  assign slot_idx = IW'(slot_r);

  // Scheduler state
  logic [IW-1:0]   current, last, idx, pidx, pick_idx;
  logic            pv;
  pts_pkg::entry_t pick;

  assign sts.sched     = is_sched;
  assign sts.scan_last = (idx == IW'(pts_pkg::NUM_ENTRIES - 1));

  // Entry table with valid bits; unwritten entries read as zero
  pts_pkg::entry_t mem [pts_pkg::NUM_ENTRIES];
  logic [pts_pkg::NUM_ENTRIES-1:0] vld;
  pts_pkg::entry_t rd_data, rdv;
  logic            rd_vld, rd_en, we;
  logic [IW-1:0]   rd_addr, wa;
  pts_pkg::entry_t wd;

  assign rd_en   = ctl.fetch || ctl.scan;
  assign rd_addr = ctl.scan ? idx : (is_sched ? current : slot_idx);
  assign rdv     = rd_vld ? rd_data : '0;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      rd_vld  <= vld[rd_addr];
    end
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[wa] <= 1'b1;
    end
  end

  // Prepared entry for the command phase
  pts_pkg::entry_t prep_e;
  logic            prep_we;

  always_comb begin
    prep_e  = rdv;
    prep_we = 1'b0;
    if (is_sched) begin
      if (cmd_r == pts_pkg::CMD_STOP) begin
        prep_e.state = pts_pkg::ST_STOPPED;
      end
      if (prep_e.state == pts_pkg::ST_RUNNING) begin
        prep_e.state   = pts_pkg::ST_READY;
        prep_e.counter = '0;
      end
      prep_we = 1'b1;
    end else if (slot_ok) begin
      unique case (cmd_r)
        pts_pkg::CMD_WRITE: begin
          prep_e  = new_r;
          prep_we = 1'b1;
        end
        pts_pkg::CMD_READY: begin
          prep_e.state   = pts_pkg::ST_READY;
          prep_e.counter = '0;
          prep_we        = 1'b1;
        end
        pts_pkg::CMD_RESUME: begin
          if (rdv.state == pts_pkg::ST_STOPPED) begin
            prep_e.state   = pts_pkg::ST_READY;
            prep_e.counter = '0;
            prep_we        = 1'b1;
          end
        end
        default: ;
      endcase
    end else begin
      prep_e = '0;
    end
  end

  // Winner entry
  pts_pkg::entry_t win_e;
  logic signed [9:0] sh;
  logic [4:0]        sh_amt;
  logic [25:0]       qv;

  always_comb begin
    sh = 10'(level_of(user_prio)) + 10'sd1;
    if (sh < 10'sd0) begin
      sh_amt = 5'd0;
    end else if (sh > 10'sd16) begin
      sh_amt = 5'd16;
    end else begin
      sh_amt = 5'(sh);
    end
    qv             = 26'(quantum) << sh_amt;
    win_e          = pick;
    win_e.prio     = user_prio;
    win_e.state    = pts_pkg::ST_RUNNING;
    win_e.counter  = policy[1] ? ((|qv[25:16]) ? 16'hFFFF : qv[15:0]) : 16'(quantum);
  end

  // Scan compare and write port
  logic cand_wins;
  assign cand_wins = beats(rdv, pick, policy);

  always_comb begin
    we = 1'b0;
    wa = slot_idx;
    wd = prep_e;
    if (ctl.prep) begin
      we = prep_we;
      wa = is_sched ? current : slot_idx;
    end else if (ctl.win) begin
      we = 1'b1;
      wa = pick_idx;
      wd = win_e;
    end else if (pv && (pidx != '0) && (rdv.state == pts_pkg::ST_READY)) begin
      we = 1'b1;
      if (cand_wins) begin
        wa = pick_idx;
        wd = bumped(pick);
      end else begin
        wa = pidx;
        wd = bumped(rdv);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv      <= 1'b0;
      current <= '0;
      last    <= '0;
      done    <= 1'b0;
    end else begin
      pv   <= ctl.scan;
      done <= (ctl.prep && !is_sched) || ctl.win;
      if (ctl.prep && is_sched) begin
        last <= current;
      end
      if (ctl.win) begin
        current <= pick_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    pidx <= idx;
    if (ctl.prep) begin
      idx <= '0;
    end else if (ctl.scan) begin
      idx <= idx + IW'(1);
    end
    if (pv) begin
      if (pidx == '0) begin
        pick     <= rdv;
        pick_idx <= '0;
      end else if ((rdv.state == pts_pkg::ST_READY) && cand_wins) begin
        pick     <= rdv;
        pick_idx <= pidx;
      end
    end
  end

  // Result registers
  pts_pkg::entry_t res;

  always_ff @(posedge clk) begin
    if (ctl.prep && !is_sched) begin
      res      <= prep_e;
      switched <= 1'b0;
    end else if (ctl.win) begin
      res      <= win_e;
      switched <= (pick_idx != current);
    end
  end

  assign chosen      = 6'(current);
  assign previous    = 6'(last);
  assign rd_state    = res.state;
  assign rd_priority = res.prio;
  assign rd_nice     = res.nice;
  assign rd_counter  = res.counter;

endmodule

// ===== dv/process_table_scheduler_tb.sv =====
// Self-checking testbench for the process table scheduler: directed and random commands.
`timescale 1ns / 1ps

module process_table_scheduler_tb;
  import pts_pkg::*;

  // Commands beyond the package list: read, plus the two unknown codes
  localparam logic [2:0] CMD_READ  = 3'd5;
  localparam logic [2:0] CMD_ODD6  = 3'd6;
  localparam logic [2:0] CMD_ODD7  = 3'd7;
  localparam logic [2:0] ST_UNUSED = 3'd0;
  localparam logic [2:0] ST_WAIT   = 3'd4;
  localparam int CNT_MAX     = 65535;
  localparam int DRAIN_WAIT  = 80;      // long enough for a schedule's walk of the whole table
  localparam int CYCLE_LIMIT = 2000000;
  localparam int RAND_ITEMS  = 1820;

  typedef struct packed {
    logic [5:0]        chosen;
    logic              switched;
    logic [5:0]        previous;
    logic [2:0]        state;
    logic signed [7:0] prio;
    logic [5:0]        nice;
    logic [15:0]       counter;
  } answer_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [2:0]        cmd = '0;
  logic [5:0]        slot = '0;
  logic [2:0]        new_state = '0;
  logic signed [7:0] new_priority = '0;
  logic [5:0]        new_nice = '0;
  logic [15:0]       new_counter = '0;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_idx = '0;
  logic [9:0]        cfg_data = '0;
  logic              done;
  logic [5:0]        chosen;
  logic              switched;
  logic [5:0]        previous;
  logic [2:0]        rd_state;
  logic signed [7:0] rd_priority;
  logic [5:0]        rd_nice;
  logic [15:0]       rd_counter;

  process_table_scheduler u_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the table, pointers and registers
  entry_t            shadow_tbl [NUM_ENTRIES];
  logic [5:0]        shadow_cur, shadow_last;
  logic [1:0]        shadow_policy;
  logic [9:0]        shadow_quantum;
  logic signed [7:0] shadow_uprio;

  answer_t pending_answers [$];
  int      fail_count = 0;
  int      cycle_count = 0;
  int      burst_left = 0;

  function automatic int level_of(int p);
    return p / LEVEL_DIV;  // truncates toward zero
  endfunction

  // True when candidate c takes the pick from n under the current policy
  function automatic bit wins_over(entry_t c, entry_t n);
    int kc, kn, lc, ln;
    if (shadow_policy == 2'd0) return c.counter > n.counter;
    if (shadow_policy == 2'd1) begin
      kc = 10 * int'(c.prio) - int'(c.counter);
      kn = 10 * int'(n.prio) - int'(n.counter);
      if (kc != kn) return kc < kn;
      return c.nice <= n.nice;
    end
    // Multilevel queue; the unused policy code behaves the same
    lc = level_of(c.prio);
    ln = level_of(n.prio);
    if (lc == ln)
      return (int'(c.nice) - int'(c.counter)) <= (int'(n.nice) - int'(n.counter));
    return lc < ln;
  endfunction

  function automatic void bump_counter(int idx);
    if (shadow_tbl[idx].counter != CNT_MAX[15:0])
      shadow_tbl[idx].counter = shadow_tbl[idx].counter + 16'd1;
  endfunction

  function automatic void run_schedule();
    int pick, sh;
    longint v;
    pick = 0;
    if (shadow_tbl[shadow_cur].state == ST_RUNNING) begin
      shadow_tbl[shadow_cur].state   = ST_READY;
      shadow_tbl[shadow_cur].counter = '0;
    end
    shadow_last = shadow_cur;
    for (int i = 1; i < NUM_ENTRIES; i++) begin
      if (shadow_tbl[i].state != ST_READY) continue;
      if (wins_over(shadow_tbl[i], shadow_tbl[pick])) begin
        bump_counter(pick);
        pick = i;
      end else begin
        bump_counter(i);
      end
    end
    shadow_tbl[pick].prio  = shadow_uprio;
    shadow_tbl[pick].state = ST_RUNNING;
    if (shadow_policy >= 2'd2) begin
      sh = level_of(shadow_uprio) + 1;
      if (sh < 0) sh = 0;
      if (sh > 16) sh = 16;
      v = longint'(shadow_quantum) << sh;
      shadow_tbl[pick].counter = (v > CNT_MAX) ? CNT_MAX[15:0] : v[15:0];
    end else begin
      shadow_tbl[pick].counter = {6'd0, shadow_quantum};
    end
    shadow_cur = pick[5:0];
  endfunction

  // Apply one accepted command to the shadow and return its answer
  function automatic answer_t apply_command(logic [2:0] c, logic [5:0] s, entry_t wr);
    answer_t a;
    logic [5:0] prev, shown;
    prev  = shadow_cur;
    shown = s;
    case (c)
      CMD_WRITE: shadow_tbl[s] = wr;
      CMD_READY: begin
        shadow_tbl[s].state   = ST_READY;
        shadow_tbl[s].counter = '0;
      end
      CMD_RESUME: begin
        if (shadow_tbl[s].state == ST_STOPPED) begin
          shadow_tbl[s].state   = ST_READY;
          shadow_tbl[s].counter = '0;
        end
      end
      CMD_STOP, CMD_SCHED: begin
        if (c == CMD_STOP) shadow_tbl[shadow_cur].state = ST_STOPPED;
        run_schedule();
        shown = shadow_cur;
      end
      default: ;
    endcase
    a.chosen   = shadow_cur;
    a.switched = ((c == CMD_STOP) || (c == CMD_SCHED)) && (shadow_cur != prev);
    a.previous = shadow_last;
    a.state    = shadow_tbl[shown].state;
    a.prio     = shadow_tbl[shown].prio;
    a.nice     = shadow_tbl[shown].nice;
    a.counter  = shadow_tbl[shown].counter;
    return a;
  endfunction

  // Check every result against the oldest expectation
  always @(posedge clk) begin
    answer_t e;
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        $error("result with no expectation waiting");
        fail_count++;
      end else begin
        e = pending_answers.pop_front();
        if (chosen !== e.chosen) begin
          $error("chosen exp %0d got %0d", e.chosen, chosen); fail_count++;
        end
        if (switched !== e.switched) begin
          $error("switched exp %0d got %0d", e.switched, switched); fail_count++;
        end
        if (previous !== e.previous) begin
          $error("previous exp %0d got %0d", e.previous, previous); fail_count++;
        end
        if (rd_state !== e.state) begin
          $error("rd_state exp %0d got %0d", e.state, rd_state); fail_count++;
        end
        if (rd_priority !== e.prio) begin
          $error("rd_priority exp %0d got %0d", e.prio, rd_priority); fail_count++;
        end
        if (rd_nice !== e.nice) begin
          $error("rd_nice exp %0d got %0d", e.nice, rd_nice); fail_count++;
        end
        if (rd_counter !== e.counter) begin
          $error("rd_counter exp %0d got %0d", e.counter, rd_counter); fail_count++;
        end
      end
    end
  end

  // Watchdog: end a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Send one command; commands go in bursts with random gaps between them
  task automatic send_cmd(logic [2:0] c, logic [5:0] s, logic [2:0] st = ST_READY,
                          logic [7:0] pr = 8'd0, logic [5:0] ni = 6'd0,
                          logic [15:0] cn = 16'd0);
    entry_t wr;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 9)) @(posedge clk);
    end
    burst_left--;
    @(posedge clk);
    start        <= 1'b1;
    cmd          <= c;
    slot         <= s;
    new_state    <= st;
    new_priority <= pr;
    new_nice     <= ni;
    new_counter  <= cn;
    // Hold until the transfer happens
    do @(posedge clk); while (busy);
    wr.state   = st;
    wr.prio    = pr;
    wr.nice    = ni;
    wr.counter = cn;
    pending_answers.push_back(apply_command(c, s, wr));
    start <= 1'b0;
  endtask

  // Wait for every answer, then let a schedule with no answer left finish
  task automatic drain();
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [9:0] val);
    drain();
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_POLICY:  shadow_policy  = val[1:0];
      REG_QUANTUM: shadow_quantum = val;
      REG_UPRIO:   shadow_uprio   = val[7:0];
      default: ;
    endcase
  endtask

  // Reset leaves everything unused; read both ends of the table
  task automatic test_reset_state();
    send_cmd(CMD_READ, 6'd0);
    send_cmd(CMD_READ, 6'd63);
  endtask

  // Field extremes, every command, odd state codes and the stop-while-idle case
  task automatic test_directed();
    send_cmd(CMD_STOP, 6'd0);                 // stop while idle, nothing ready
    send_cmd(CMD_SCHED, 6'd0);
    send_cmd(CMD_WRITE, 6'd63, ST_READY, 8'h7f, 6'd63, 16'hffff);
    send_cmd(CMD_WRITE, 6'd1, ST_READY, 8'h80, 6'd0, 16'hfffe);
    send_cmd(CMD_WRITE, 6'd2, 3'd7, 8'h00, 6'd21, 16'd5);  // never ready
    send_cmd(CMD_WRITE, 6'd3, 3'd5, 8'h10, 6'd42, 16'd9);
    send_cmd(CMD_WRITE, 6'd4, ST_STOPPED, 8'hf6, 6'd7, 16'd100);
    send_cmd(CMD_RESUME, 6'd4);
    send_cmd(CMD_RESUME, 6'd3);               // not stopped: no change
    send_cmd(CMD_READY, 6'd5);
    send_cmd(CMD_SCHED, 6'd0);
    send_cmd(CMD_SCHED, 6'd0);
    send_cmd(CMD_STOP, 6'd0);
    send_cmd(CMD_WRITE, 6'd6, ST_WAIT, 8'h05, 6'd1, 16'd0);
    send_cmd(CMD_WRITE, 6'd7, ST_RUNNING, 8'hff, 6'd2, 16'd3);
    send_cmd(CMD_ODD6, 6'd7);
    send_cmd(CMD_ODD7, 6'd63);
    send_cmd(CMD_READ, 6'd2);
    send_cmd(CMD_SCHED, 6'd0);
    send_cmd(CMD_WRITE, 6'd0, ST_UNUSED, 8'h00, 6'd0, 16'd0);
  endtask

  // Random traffic: mostly well-formed table set-up and schedules
  task automatic test_random(int n);
    int w;
    logic [2:0] c, st;
    logic [15:0] cn;
    for (int k = 0; k < n; k++) begin
      w  = $urandom_range(0, 99);
      st = ($urandom_range(0, 3) != 0) ? ST_READY : 3'($urandom_range(0, 7));
      cn = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(65500, 65535))
                                       : 16'($urandom_range(0, 65535));
      if (w < 30)      c = CMD_WRITE;
      else if (w < 44) c = CMD_READY;
      else if (w < 52) c = CMD_RESUME;
      else if (w < 62) c = CMD_STOP;
      else if (w < 84) c = CMD_SCHED;
      else if (w < 95) c = CMD_READ;
      else             c = ($urandom_range(0, 1) != 0) ? CMD_ODD6 : CMD_ODD7;
      send_cmd(c, 6'($urandom_range(0, 63)), st, 8'($urandom_range(0, 255)),
               6'($urandom_range(0, 63)), cn);
      // Pause once, mid-run, until every answer is back
      if (k == n / 2) drain();
    end
  endtask

  // Walk through register settings, the extremes among them
  task automatic test_settings();
    logic [1:0] pols [4]  = '{2'd0, 2'd1, 2'd2, 2'd3};
    logic [9:0] quants [4] = '{10'd1, 10'd1023, 10'd0, 10'd50};
    logic [7:0] uprios [4] = '{8'h80, 8'h7f, 8'h00, 8'd40};
    for (int p = 0; p < 4; p++) begin
      write_reg(REG_POLICY, {8'd0, pols[p]});
      write_reg(REG_QUANTUM, quants[p]);
      write_reg(REG_UPRIO, {2'd0, uprios[p]});
      test_random(RAND_ITEMS / 4);
    end
  endtask

  initial begin
    foreach (shadow_tbl[i]) shadow_tbl[i] = '0;
    shadow_cur     = '0;
    shadow_last    = '0;
    shadow_policy  = 2'd2;
    shadow_quantum = 10'd50;
    shadow_uprio   = 8'sd40;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_directed();
    test_settings();
    drain();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
